// ===== hdl/prp_pkg.sv =====
// Shared types and constants for the point rotate / projection block.
package prp_pkg;

    localparam int ANGLE_W    = 16;
    localparam int TRIG_W     = 16;
    localparam int POINT_W    = 8;
    localparam int ROT_W      = 26;
    localparam int DIST_W     = 8;
    localparam int SCALE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int INDEX_W    = 12;
    localparam int DCLASS_W   = 2;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [DIST_W-1:0]  DIST_RESET   = 8'd40;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 8'd40;

    // depth thresholds in Q16
    localparam logic signed [ROT_W-1:0] DEPTH_NEAR_LIM = -ROT_W'(5 * 65536);
    localparam logic signed [ROT_W-1:0] DEPTH_MID_LIM  = ROT_W'(5 * 65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_X  = 3'd0,
        REG_ANGLE_Y  = 3'd1,
        REG_ANGLE_Z  = 3'd2,
        REG_CAM_DIST = 3'd3,
        REG_SCALE    = 3'd4
    } t_reg_idx;

    typedef enum logic [DCLASS_W-1:0] {
        DEPTH_NEAR = 2'd0,
        DEPTH_MID  = 2'd1,
        DEPTH_FAR  = 2'd2
    } t_depth;

    typedef struct packed {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic signed [POINT_W-1:0] z;
    } t_point;

    // side info that rides along the divider
    typedef struct packed {
        logic   den_ok;
        t_depth depth;
    } t_side;

endpackage

// ===== hdl/prp_trig.sv =====
// Quarter-wave sine table and sine/cosine lookup for one angle.
module prp_trig
    import prp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic [ANGLE_W-1:0]       i_angle,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = 14 + IDX_W;

    // polynomial quarter wave, Q1.15, evaluated at elaboration
    function automatic logic [TRIG_W-1:0] sine_entry(input int k);
        longint unsigned u, u2, inner, mid, q30, q15;
        u     = (longint'(k) * 64'd65536) / SINE_TABLE_DEPTH;
        u2    = (u * u) >> 16;
        inner = 64'd690734250 - ((u2 * 64'd78071983) >> 16);
        mid   = 64'd1686557207 - ((u2 * inner) >> 16);
        q30   = (u * mid) >> 16;
        q15   = (q30 + 64'd16384) >> 15;
        if (q15 > 64'd32767) begin
            q15 = 64'd32767;
        end
        return TRIG_W'(q15);
    endfunction

    logic [TRIG_W-1:0]        rom [SINE_TABLE_DEPTH+1];
    logic [ANGLE_W-1:0]       ang [2];
    logic signed [TRIG_W-1:0] res [2];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        assign rom[k] = sine_entry(k);
    end

    assign ang[0] = i_angle;
    assign ang[1] = i_angle + QUARTER_TURN;   // cos = sin(a + quarter)

    for (genvar j = 0; j < 2; j++) begin : g_look
        logic [1:0]        quad;
        logic [PROD_W-1:0] prod;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  addr;
        logic [TRIG_W-1:0] mag;
        assign quad = ang[j][15:14];
        assign prod = PROD_W'(ang[j][13:0]) * PROD_W'(SINE_TABLE_DEPTH);
        assign idx  = prod[PROD_W-1:14];
        assign addr = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
        assign mag  = rom[addr];
        assign res[j] = quad[1] ? -$signed(mag) : $signed(mag);
    end

    assign o_sin = res[0];
    assign o_cos = res[1];

endmodule

// ===== hdl/prp_rot.sv =====
// Six-stage rotation pipeline: trig lookup, matrix build, point multiply, sum.
module prp_rot
    import prp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  t_point                   i_pt,
    input  logic [ANGLE_W-1:0]       i_ang_x,
    input  logic [ANGLE_W-1:0]       i_ang_y,
    input  logic [ANGLE_W-1:0]       i_ang_z,
    output logic                     o_vld,
    output logic signed [ROT_W-1:0]  o_rx,
    output logic signed [ROT_W-1:0]  o_ry,
    output logic signed [ROT_W-1:0]  o_rz
);

    localparam int NSTG  = 6;
    localparam int P2_W  = 32;       // Q30 products
    localparam int MAT_W = 48;       // Q45 matrix
    localparam int MP_W  = MAT_W + POINT_W;
    localparam int SUM_W = MP_W + 2;
    localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'(32'h1FFF_FFFF);

    logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

    prp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_x (
        .i_angle(i_ang_x), .o_sin(sx), .o_cos(cx));
    prp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_y (
        .i_angle(i_ang_y), .o_sin(sy), .o_cos(cy));
    prp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_z (
        .i_angle(i_ang_z), .o_sin(sz), .o_cos(cz));

    logic [NSTG-1:0] r_vld;
    t_point          r_pt [4];

    // stage 1
    logic signed [TRIG_W-1:0] r1_sx, r1_cx, r1_sy, r1_cy, r1_sz, r1_cz;
    // stage 2
    logic signed [P2_W-1:0]   r2_sxsy, r2_cxsy;
    logic signed [TRIG_W-1:0] r2_sx, r2_cx, r2_sy, r2_cy, r2_sz, r2_cz;
    // stage 3
    logic signed [MAT_W-1:0]  r3_t1, r3_t2, r3_t3, r3_t4;
    logic signed [P2_W-1:0]   r3_cycz, r3_cxsz, r3_sxsz, r3_cxcz;
    logic signed [P2_W-1:0]   r3_sxcz, r3_cysz, r3_cxcy, r3_sxcy;
    logic signed [TRIG_W-1:0] r3_sy;
    // stage 4, 5
    logic signed [MAT_W-1:0]  r4_m [9];
    logic signed [MP_W-1:0]   r5_p [9];
    // stage 6
    logic signed [ROT_W-1:0]  r6_r [3];

    logic signed [SUM_W-1:0]  sum [3];
    logic signed [SUM_W-1:0]  tsum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt[0] <= i_pt;
        for (int i = 1; i < 4; i++) begin
            r_pt[i] <= r_pt[i-1];
        end

        r1_sx <= sx; r1_cx <= cx; r1_sy <= sy;
        r1_cy <= cy; r1_sz <= sz; r1_cz <= cz;

        r2_sxsy <= r1_sx * r1_sy;
        r2_cxsy <= r1_cx * r1_sy;
        r2_sx <= r1_sx; r2_cx <= r1_cx; r2_sy <= r1_sy;
        r2_cy <= r1_cy; r2_sz <= r1_sz; r2_cz <= r1_cz;

        r3_t1   <= r2_sxsy * r2_cz;
        r3_t2   <= r2_cxsy * r2_cz;
        r3_t3   <= r2_sxsy * r2_sz;
        r3_t4   <= r2_cxsy * r2_sz;
        r3_cycz <= r2_cy * r2_cz;
        r3_cxsz <= r2_cx * r2_sz;
        r3_sxsz <= r2_sx * r2_sz;
        r3_cxcz <= r2_cx * r2_cz;
        r3_sxcz <= r2_sx * r2_cz;
        r3_cysz <= r2_cy * r2_sz;
        r3_cxcy <= r2_cx * r2_cy;
        r3_sxcy <= r2_sx * r2_cy;
        r3_sy   <= r2_sy;

        // row-major rotation matrix in Q45
        r4_m[0] <= MAT_W'(r3_cycz) <<< 15;
        r4_m[1] <= r3_t1 + (MAT_W'(r3_cxsz) <<< 15);
        r4_m[2] <= (MAT_W'(r3_sxsz) <<< 15) - r3_t2;
        r4_m[3] <= -(MAT_W'(r3_cysz) <<< 15);
        r4_m[4] <= (MAT_W'(r3_cxcz) <<< 15) - r3_t3;
        r4_m[5] <= (MAT_W'(r3_sxcz) <<< 15) + r3_t4;
        r4_m[6] <= MAT_W'(r3_sy) <<< 30;
        r4_m[7] <= -(MAT_W'(r3_sxcy) <<< 15);
        r4_m[8] <= MAT_W'(r3_cxcy) <<< 15;

        for (int r = 0; r < 3; r++) begin
            r5_p[r*3]   <= r4_m[r*3]   * r_pt[3].x;
            r5_p[r*3+1] <= r4_m[r*3+1] * r_pt[3].y;
            r5_p[r*3+2] <= r4_m[r*3+2] * r_pt[3].z;
        end

        for (int r = 0; r < 3; r++) begin
            r6_r[r] <= ROT_W'(tsum[r] >>> 29);
        end
    end

    // Q45 -> Q16, truncating toward zero
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r]  = SUM_W'(r5_p[r*3]) + SUM_W'(r5_p[r*3+1]) + SUM_W'(r5_p[r*3+2]);
            tsum[r] = sum[r][SUM_W-1] ? (sum[r] + TRUNC_BIAS) : sum[r];
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_rx  = r6_r[0];
    assign o_ry  = r6_r[1];
    assign o_rz  = r6_r[2];

endmodule

// ===== hdl/prp_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, saturating.
module prp_div
    import prp_pkg::*;
#(
    parameter int QB    = 15,
    parameter int NUM_W = 43,
    parameter int DEN_W = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic                 i_neg [2],
    input  logic [NUM_W-1:0]     i_num [2],
    input  logic [DEN_W-1:0]     i_den,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic signed [QB:0]   o_quo [2],
    output t_side                o_side
);

    localparam int CW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

    logic [QB:0]       r_vld;
    logic [CW-1:0]     r_rem  [QB+1][2];
    logic [QB-1:0]     r_q    [QB+1][2];
    logic              r_neg  [QB+1][2];
    logic              r_ovf  [QB+1][2];
    logic [DEN_W-1:0]  r_den  [QB+1];
    t_side             r_side [QB+1];

    logic [CW-1:0]     dshift [QB];
    logic [CW:0]       trial  [QB][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QB-1:0], i_vld};
        end
    end

    always_comb begin
        for (int s = 0; s < QB; s++) begin
            dshift[s] = CW'(r_den[s]) << (QB - 1 - s);
            for (int l = 0; l < 2; l++) begin
                trial[s][l] = {1'b0, r_rem[s][l]} - {1'b0, dshift[s]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // entry: overflow check against den << QB
        for (int l = 0; l < 2; l++) begin
            r_rem[0][l] <= CW'(i_num[l]);
            r_q[0][l]   <= '0;
            r_neg[0][l] <= i_neg[l];
            r_ovf[0][l] <= CW'(i_num[l]) >= (CW'(i_den) << QB);
        end
        r_den[0]  <= i_den;
        r_side[0] <= i_side;

        for (int s = 0; s < QB; s++) begin
            for (int l = 0; l < 2; l++) begin
                if (!trial[s][l][CW]) begin
                    r_rem[s+1][l] <= trial[s][l][CW-1:0];
                end else begin
                    r_rem[s+1][l] <= r_rem[s][l];
                end
                r_q[s+1][l]   <= {r_q[s][l][QB-2:0], ~trial[s][l][CW]};
                r_neg[s+1][l] <= r_neg[s][l];
                r_ovf[s+1][l] <= r_ovf[s][l];
            end
            r_den[s+1]  <= r_den[s];
            r_side[s+1] <= r_side[s];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_out
        logic [QB:0] mag;
        assign mag = r_ovf[QB][l] ? {1'b0, {QB{1'b1}}} : {1'b0, r_q[QB][l]};
        assign o_quo[l] = r_neg[QB][l] ? -$signed(mag) : $signed(mag);
    end

    assign o_vld  = r_vld[QB];
    assign o_side = r_side[QB];

endmodule

// ===== hdl/point_rotate_project_to_screen.sv =====
// Top level: config registers, rotation, perspective divide and screen mapping.
//
// A point is taken on any cycle where i_start is high and o_busy is low; one
// point per clock is sustained with no gaps. Each point gives exactly one
// result, shown for one cycle with o_strobe, in order. The pipeline runs
// through the rotation, a numerator/denominator register, the divider and
// the screen map with its output register. QB = clog2(max(W,H)*128+256)+1
// is the divider's quotient width; the divider, one quotient bit per stage,
// sets the depth. The receiver cannot stall, so nothing ever holds
// the pipeline. o_busy is high only during reset and the cycle after it.
// Configuration writes are registered and must come only while no point is
// in flight. Points whose depth plus camera distance is not positive are
// reported off screen with index 0; the depth class is always valid.
module point_rotate_project_to_screen
    import prp_pkg::*;
#(
    parameter int SCREEN_WIDTH     = 80,
    parameter int SCREEN_HEIGHT    = 40,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [POINT_W-1:0]   i_point_x,
    input  logic signed [POINT_W-1:0]   i_point_y,
    input  logic signed [POINT_W-1:0]   i_point_z,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_on_screen,
    output logic [INDEX_W-1:0]          o_screen_index,
    output logic [DCLASS_W-1:0]         o_depth_class
);

    localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int QB      = $clog2(MAX_DIM * 128 + 256) + 1;
    localparam int MUL_W   = ROT_W + SCALE_W + 1;
    localparam int NUM_W   = MUL_W + 8;
    localparam int DEN_W   = ROT_W + 1;
    localparam int C8_W    = QB + 2;
    localparam int COL_W   = $clog2(SCREEN_WIDTH);
    localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
    localparam int LIN_W   = COL_W + ROW_W;

    localparam logic signed [C8_W-1:0] COL_OFS = C8_W'(SCREEN_WIDTH * 128);
    localparam logic signed [C8_W-1:0] ROW_OFS = C8_W'(SCREEN_HEIGHT * 128);
    localparam logic signed [C8_W-1:0] COL_LIM = C8_W'(SCREEN_WIDTH * 256);
    localparam logic signed [C8_W-1:0] ROW_LIM = C8_W'(SCREEN_HEIGHT * 256);
    localparam logic signed [C8_W-1:0] NEG_LIM = C8_W'(-255);

    // ---------------- configuration ----------------
    logic [ANGLE_W-1:0] r_ang_x, r_ang_y, r_ang_z;
    logic [DIST_W-1:0]  r_cam_dist;
    logic [SCALE_W-1:0] r_scale;
    logic               r_busy;
    logic               cfg_xfer;

    assign o_busy      = r_busy;
    assign o_cfg_ready = !r_busy;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // unknown indexes are dropped; wide data keeps its low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x    <= '0;
            r_ang_y    <= '0;
            r_ang_z    <= '0;
            r_cam_dist <= DIST_RESET;
            r_scale    <= SCALE_RESET;
        end else if (cfg_xfer) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ANGLE_X:  r_ang_x    <= i_cfg_data;
                REG_ANGLE_Y:  r_ang_y    <= i_cfg_data;
                REG_ANGLE_Z:  r_ang_z    <= i_cfg_data;
                REG_CAM_DIST: r_cam_dist <= i_cfg_data[DIST_W-1:0];
                REG_SCALE:    r_scale    <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- rotation ----------------
    t_point                  in_pt;
    logic                    rot_vld;
    logic signed [ROT_W-1:0] rot_x, rot_y, rot_z;

    assign in_pt = '{x: i_point_x, y: i_point_y, z: i_point_z};

    prp_rot #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start && !r_busy),
        .i_pt    (in_pt),
        .i_ang_x (r_ang_x),
        .i_ang_y (r_ang_y),
        .i_ang_z (r_ang_z),
        .o_vld   (rot_vld),
        .o_rx    (rot_x),
        .o_ry    (rot_y),
        .o_rz    (rot_z)
    );

    // ---------------- numerators, denominator, depth class ----------------
    logic signed [MUL_W-1:0] mul_x, mul_y;
    logic signed [NUM_W-1:0] num_x, num_y;
    logic signed [DEN_W-1:0] den;
    t_depth                  depth;

    assign mul_x = rot_x * $signed({1'b0, r_scale});
    assign mul_y = rot_y * $signed({1'b0, r_scale});
    assign num_x = NUM_W'(mul_x) <<< 8;
    assign num_y = NUM_W'(mul_y) <<< 7;   // vertical gain is half
    assign den   = DEN_W'(rot_z) + $signed({1'b0, r_cam_dist, 16'h0000});

    always_comb begin
        if (rot_z <= DEPTH_NEAR_LIM) begin
            depth = DEPTH_NEAR;
        end else if (rot_z <= DEPTH_MID_LIM) begin
            depth = DEPTH_MID;
        end else begin
            depth = DEPTH_FAR;
        end
    end

    logic               r1_vld;
    logic               r1_neg [2];
    logic [NUM_W-1:0]   r1_num [2];
    logic [DEN_W-2:0]   r1_den;
    t_side              r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= rot_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_neg[0] <= num_x[NUM_W-1];
        r1_neg[1] <= num_y[NUM_W-1];
        r1_num[0] <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
        r1_num[1] <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
        r1_den    <= den[DEN_W-2:0];
        r1_side   <= '{den_ok: (den > 0), depth: depth};
    end

    // ---------------- perspective divide ----------------
    logic              div_vld;
    logic signed [QB:0] quo [2];
    t_side             div_side;

    prp_div #(.QB(QB), .NUM_W(NUM_W), .DEN_W(DEN_W - 1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_neg   (r1_neg),
        .i_num   (r1_num),
        .i_den   (r1_den),
        .i_side  (r1_side),
        .o_vld   (div_vld),
        .o_quo   (quo),
        .o_side  (div_side)
    );

    // ---------------- screen mapping ----------------
    logic signed [C8_W-1:0] col8, row8;
    logic                   in_bounds;

    assign col8 = C8_W'(quo[0]) + COL_OFS;
    assign row8 = C8_W'(quo[1]) + ROW_OFS;
    // column/row truncate toward zero, so -255..-1 still maps to 0
    assign in_bounds = (col8 >= NEG_LIM) && (col8 < COL_LIM)
                    && (row8 >= NEG_LIM) && (row8 < ROW_LIM);

    logic             r2_vld;
    logic             r2_on;
    logic [COL_W-1:0] r2_col;
    logic [ROW_W-1:0] r2_row;
    t_depth           r2_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_on    <= div_side.den_ok && in_bounds;
        r2_col   <= col8[C8_W-1] ? '0 : COL_W'(col8 >>> 8);
        r2_row   <= row8[C8_W-1] ? '0 : ROW_W'(row8 >>> 8);
        r2_depth <= div_side.depth;
    end

    // ---------------- output register ----------------
    logic               r_out_vld;
    logic               r_out_on;
    logic [INDEX_W-1:0] r_out_idx;
    t_depth             r_out_depth;
    logic [LIN_W-1:0]   lin;

    assign lin = LIN_W'(r2_row) * LIN_W'(SCREEN_WIDTH) + LIN_W'(r2_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_on    <= r2_on;
        r_out_idx   <= r2_on ? INDEX_W'(lin) : '0;
        r_out_depth <= r2_depth;
    end

    assign o_strobe       = r_out_vld;
    assign o_on_screen    = r_out_on;
    assign o_screen_index = r_out_idx;
    assign o_depth_class  = r_out_depth;

endmodule

// ===== hdl/prp_chk.sv =====
// Port-level assertions for the projection block, with bind.
module prp_chk
    import prp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 40
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_busy,
    input logic                o_strobe,
    input logic                o_on_screen,
    input logic [INDEX_W-1:0]  o_screen_index,
    input logic [DCLASS_W-1:0] o_depth_class
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && o_busy))
        else $error("strobe or not busy right after reset");

    a_depth_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_depth_class != 2'd3))
        else $error("bad depth class");

    a_off_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_on_screen) |-> (o_screen_index == '0))
        else $error("nonzero index for off-screen point");

    a_on_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_on_screen) |-> (int'(o_screen_index) < SCREEN_WIDTH * SCREEN_HEIGHT))
        else $error("screen index out of range");

endmodule

bind point_rotate_project_to_screen prp_chk #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_prp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_strobe       (o_strobe),
    .o_on_screen    (o_on_screen),
    .o_screen_index (o_screen_index),
    .o_depth_class  (o_depth_class)
);

// ===== verif/point_rotate_project_to_screen_tb.sv =====
// Self-checking testbench for point_rotate_project_to_screen: random points, configs and gaps.
`timescale 1ns / 1ps

module point_rotate_project_to_screen_tb;
    import prp_pkg::*;

    localparam int SCR_W      = 80;
    localparam int SCR_H      = 40;
    localparam int LUT_DEPTH  = 256;
    localparam int DRAIN_WAIT = 40;     // pipeline is 25 deep at 80x40
    localparam int NUM_PHASES = 12;

    typedef struct packed {
        logic               on_screen;
        logic [INDEX_W-1:0] index;
        logic [DCLASS_W-1:0] depth;
    } t_pixel;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic signed [POINT_W-1:0] i_point_x;
    logic signed [POINT_W-1:0] i_point_y;
    logic signed [POINT_W-1:0] i_point_z;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      o_strobe;
    logic                      o_on_screen;
    logic [INDEX_W-1:0]        o_screen_index;
    logic [DCLASS_W-1:0]       o_depth_class;

    point_rotate_project_to_screen u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_on_screen    (o_on_screen),
        .o_screen_index (o_screen_index),
        .o_depth_class  (o_depth_class)
    );

    // Shadow copy of the register file, updated on each config transfer.
    logic [ANGLE_W-1:0] ang_x, ang_y, ang_z;
    logic [DIST_W-1:0]  cam_dist;
    logic [SCALE_W-1:0] proj_scale;

    t_point pending_points[$];
    t_pixel expected_pixels[$];
    int     gap_left;
    bit     gaps_on;
    int     errors;

    // Quarter-wave sine entry, Q1.15, polynomial evaluated in fixed point.
    function automatic longint sine_entry(input longint unsigned k);
        longint unsigned u, u2, inner, mid, q30, q15;
        u     = (k * 65536) / LUT_DEPTH;
        u2    = (u * u) >> 16;
        inner = 64'd690734250 - ((u2 * 64'd78071983) >> 16);
        mid   = 64'd1686557207 - ((u2 * inner) >> 16);
        q30   = (u * mid) >> 16;
        q15   = (q30 + 16384) >> 15;
        if (q15 > 32767) q15 = 32767;
        return longint'(q15);
    endfunction

    function automatic longint sine_of_angle(input logic [ANGLE_W-1:0] a);
        logic [1:0]      quad;
        longint unsigned idx;
        longint          v;
        quad = a[15:14];
        idx  = (longint'(a[13:0]) * LUT_DEPTH) >> 14;
        v    = quad[0] ? sine_entry(LUT_DEPTH - idx) : sine_entry(idx);
        return quad[1] ? -v : v;
    endfunction

    function automatic t_pixel predict_pixel(input t_point p);
        longint px, py, pz, sx, cx, sy, cy, sz, cz;
        longint rx45, ry45, rz45, rx, ry, rz, den, sc, col8, row8, col, row;
        t_pixel r;
        px = p.x; py = p.y; pz = p.z;
        sx = sine_of_angle(ang_x); cx = sine_of_angle(ang_x + QUARTER_TURN);
        sy = sine_of_angle(ang_y); cy = sine_of_angle(ang_y + QUARTER_TURN);
        sz = sine_of_angle(ang_z); cz = sine_of_angle(ang_z + QUARTER_TURN);
        rx45 = py*sx*sy*cz - pz*cx*sy*cz + (py*cx*sz + pz*sx*sz + px*cy*cz) * 32768;
        ry45 = (py*cx*cz + pz*sx*cz - px*cy*sz) * 32768 - py*sx*sy*sz + pz*cx*sy*sz;
        rz45 = (pz*cx*cy - py*sx*cy) * 32768 + px*sy*64'sd1073741824;
        // Q45 -> Q16, truncating toward zero
        rx = rx45 / 64'sd536870912;
        ry = ry45 / 64'sd536870912;
        rz = rz45 / 64'sd536870912;
        r = '0;
        if (rz <= -5 * 65536)     r.depth = DEPTH_NEAR;
        else if (rz <= 5 * 65536) r.depth = DEPTH_MID;
        else                      r.depth = DEPTH_FAR;
        den = rz + longint'(cam_dist) * 65536;
        if (den > 0) begin
            sc   = proj_scale;
            col8 = (rx * sc * 256) / den + SCR_W * 128;
            row8 = (ry * sc * 128) / den + SCR_H * 128;
            col  = col8 / 256;
            row  = row8 / 256;
            if (col >= 0 && col < SCR_W && row >= 0 && row < SCR_H) begin
                r.on_screen = 1'b1;
                r.index     = INDEX_W'(row * SCR_W + col);
            end
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Driver: holds a point until accepted, then waits a drawn gap.
    always @(posedge i_clk) begin
        int     g;
        t_point p;
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            gap_left <= 0;
        end else begin
            g = gap_left;
            if (i_start && !o_busy) begin
                expected_pixels.push_back(predict_pixel({i_point_x, i_point_y, i_point_z}));
                g = gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (i_start && o_busy) begin
                gap_left <= g;
            end else if (g > 0) begin
                i_start  <= 1'b0;
                gap_left <= g - 1;
            end else if (pending_points.size() > 0) begin
                p = pending_points.pop_front();
                i_point_x <= p.x;
                i_point_y <= p.y;
                i_point_z <= p.z;
                i_start   <= 1'b1;
                gap_left  <= 0;
            end else begin
                i_start  <= 1'b0;
                gap_left <= 0;
            end
        end
    end

    // Monitor: every strobe is one result transfer, compared in order.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_strobe) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result on=%0b idx=%0d depth=%0d", $time,
                         o_on_screen, o_screen_index, o_depth_class);
            end else begin
                want = expected_pixels.pop_front();
                if (o_on_screen !== want.on_screen) begin
                    errors++;
                    $display("%0t: on_screen exp %0b got %0b", $time,
                             want.on_screen, o_on_screen);
                end
                if (o_screen_index !== want.index) begin
                    errors++;
                    $display("%0t: screen_index exp %0d got %0d", $time,
                             want.index, o_screen_index);
                end
                if (o_depth_class !== want.depth) begin
                    errors++;
                    $display("%0t: depth_class exp %0d got %0d", $time,
                             want.depth, o_depth_class);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ANGLE_X:  ang_x      = data;
            REG_ANGLE_Y:  ang_y      = data;
            REG_ANGLE_Z:  ang_z      = data;
            REG_CAM_DIST: cam_dist   = data[DIST_W-1:0];
            REG_SCALE:    proj_scale = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Full-range coordinate, or a small one so that more points land on screen.
    function automatic logic signed [POINT_W-1:0] rand_coord();
        if ($urandom_range(0, 1)) return POINT_W'($urandom);
        return POINT_W'($signed($urandom_range(0, 24)) - 12);
    endfunction

    task automatic drain();
        do @(posedge i_clk);
        while (pending_points.size() > 0 || i_start || expected_pixels.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic signed [POINT_W-1:0] ext[3];
        logic [DIST_W-1:0]         d;
        logic [SCALE_W-1:0]        s;
        errors      = 0;
        gaps_on     = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_point_x   = '0;
        i_point_y   = '0;
        i_point_z   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        ang_x = '0; ang_y = '0; ang_z = '0;
        cam_dist   = DIST_RESET;
        proj_scale = SCALE_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, edge and face centres, origin of the input cube, at reset config.
        ext = '{8'sh80, 8'sd0, 8'sd127};
        for (int i = 0; i < 27; i++)
            pending_points.push_back({ext[i % 3], ext[(i / 3) % 3], ext[i / 9]});
        drain();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            gaps_on = ph % 3 != 0;     // some phases run back-to-back
            d = DIST_W'($urandom);
            s = SCALE_W'($urandom);
            case (ph)
                1: begin write_reg(REG_ANGLE_X, '0);     write_reg(REG_ANGLE_Y, '0);
                         write_reg(REG_ANGLE_Z, '0);     d = 8'd255; s = 8'd255; end
                2: begin write_reg(REG_ANGLE_X, 16'hFFFF); write_reg(REG_ANGLE_Y, 16'hFFFF);
                         write_reg(REG_ANGLE_Z, 16'hFFFF); d = 8'd1; s = 8'd1; end
                3: begin write_reg(REG_ANGLE_X, QUARTER_TURN);
                         write_reg(REG_ANGLE_Y, CFG_DATA_W'(QUARTER_TURN * 2));
                         write_reg(REG_ANGLE_Z, CFG_DATA_W'(QUARTER_TURN * 3));
                         d = 8'd0; s = 8'd0; end
                4: begin write_reg(REG_ANGLE_X, CFG_DATA_W'(QUARTER_TURN * 2));
                         write_reg(REG_ANGLE_Y, CFG_DATA_W'(QUARTER_TURN * 3));
                         write_reg(REG_ANGLE_Z, QUARTER_TURN); d = 8'd4; end
                default: begin write_reg(REG_ANGLE_X, CFG_DATA_W'($urandom));
                         write_reg(REG_ANGLE_Y, CFG_DATA_W'($urandom));
                         write_reg(REG_ANGLE_Z, CFG_DATA_W'($urandom)); end
            endcase
            // upper data bits are junk that the 8-bit registers must drop
            write_reg(REG_CAM_DIST, (CFG_DATA_W'($urandom) & 16'hFF00) | CFG_DATA_W'(d));
            write_reg(REG_SCALE, (CFG_DATA_W'($urandom) & 16'hFF00) | CFG_DATA_W'(s));
            // unused register index, should be ignored
            write_reg(CFG_IDX_W'($urandom_range(int'(REG_SCALE) + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
            for (int i = 0; i < 77; i++)
                pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
            drain();
        end

        if (errors == 0)
            $display("point_rotate_project_to_screen: match");
        else
            $display("point_rotate_project_to_screen: mismatch");
        $finish;
    end

    initial begin
        #5ms;
        $display("point_rotate_project_to_screen: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/prp_pkg.sv
hdl/prp_trig.sv
hdl/prp_rot.sv
hdl/prp_div.sv
hdl/point_rotate_project_to_screen.sv
hdl/prp_chk.sv
verif/point_rotate_project_to_screen_tb.sv
